FILE: sv/config_packet_stream_parser_core_assert.svh
// assertion macros used by the parser back end
`ifndef CONFIG_PACKET_STREAM_PARSER_CORE_ASSERT_SVH
`define CONFIG_PACKET_STREAM_PARSER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CPSP_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpsp assertion failed");

// next-cycle implication, disabled while reset is low
`define CPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpsp assertion failed");

`endif

FILE: sv/cpsp_pkg.sv
// shared types, constants and decode functions of the configuration stream parser
package cpsp_pkg;

    localparam int FRAME_WORDS      = 101;
    localparam int FRAME_COUNT_BITS = 24;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0]  FRAME_LAST = 7'(FRAME_WORDS - 1);
    localparam logic [23:0] RUN_MAX    = 24'hffffff;

    localparam logic [31:0] DUMMY_WORD      = 32'hffffffff;
    localparam logic [31:0] WIDTH_SYNC_WORD = 32'h000000bb;
    localparam logic [31:0] WIDTH_DET_WORD  = 32'h11220044;
    localparam logic [31:0] SYNC_WORD       = 32'haa995566;
    localparam logic [31:0] NOOP_WORD       = 32'h20000000;
    localparam logic [2:0]  TYPE1_TAG       = 3'b001;
    localparam logic [2:0]  TYPE2_TAG       = 3'b010;
    localparam logic [13:0] REG_CMD         = 14'd4;
    localparam logic [13:0] REG_FAR         = 14'd1;

    typedef enum logic [3:0] {
        KIND_DUMMY      = 4'd0,
        KIND_WIDTH_SYNC = 4'd1,
        KIND_WIDTH      = 4'd2,
        KIND_SYNC       = 4'd3,
        KIND_TYPE1_HDR  = 4'd4,
        KIND_TYPE2_HDR  = 4'd5,
        KIND_UNKNOWN    = 4'd6,
        KIND_REG_DATA   = 4'd7,
        KIND_COMMAND    = 4'd8,
        KIND_ADDRESS    = 4'd9,
        KIND_FRAME_DATA = 4'd10
    } t_kind;

    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_TYPE1  = 2'd1,
        MODE_TYPE2  = 2'd2
    } t_mode;

    // classified word handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [31:0] word;
        logic [1:0]  op_code;
        logic [13:0] reg_addr;
        logic [26:0] word_count;
        logic        known_code;
        logic [6:0]  frame_offset;
        logic        frame_end;
        logic        extra_close;
    } t_token;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] raw_word;
        logic [1:0]  op_code;
        logic [13:0] reg_addr;
        logic [26:0] word_count;
        logic        known_code;
        logic [23:0] frame_number;
        logic [6:0]  frame_offset;
        logic        frame_end;
        logic        frame_nonzero;
        logic [23:0] zero_frames_before;
    } t_result;

    function automatic logic reg_known(input logic [13:0] r);
        return (r <= 14'h0e) || (r == 14'h10) || (r == 14'h11) ||
               (r == 14'h16) || (r == 14'h18);
    endfunction

    function automatic logic cmd_known(input logic [7:0] c);
        return (c <= 8'h0d) || (c == 8'h0f) || (c == 8'h10) || (c == 8'h11);
    endfunction

    function automatic logic [23:0] sat_inc(input logic [23:0] x);
        return (x == RUN_MAX) ? x : x + 24'd1;
    endfunction

endpackage

FILE: sv/cpsp_front.sv
// front end: packet state tracking and word classification
module cpsp_front
    import cpsp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  logic [31:0] i_word,
    output logic   o_push_valid,
    input  logic   i_push_ready,
    output t_token o_token
);

    t_mode       r_mode,   n_mode;
    logic [26:0] r_left,   n_left;
    logic [13:0] r_reg,    n_reg;
    logic [1:0]  r_op,     n_op;
    logic        r_single, n_single;
    logic [6:0]  r_offset, n_offset;

    logic accept;
    logic in_t1, in_t2;
    logic is_t1h, is_t2h, is_noop, is_fixed;
    logic t2_full, t2_last, t2_end;
    logic [26:0] t1_cnt, t2_cnt;

    assign accept  = i_valid && i_push_ready;
    assign o_ready = i_push_ready;

    assign in_t1   = (r_mode == MODE_TYPE1) && (r_left != '0);
    assign in_t2   = (r_mode == MODE_TYPE2) && (r_left != '0);
    assign is_fixed = (i_word == DUMMY_WORD) || (i_word == WIDTH_SYNC_WORD) ||
                      (i_word == WIDTH_DET_WORD) || (i_word == SYNC_WORD);
    assign is_t1h  = (i_word[31:29] == TYPE1_TAG);
    assign is_t2h  = (i_word[31:29] == TYPE2_TAG);
    assign is_noop = !in_t1 && !in_t2 && (i_word == NOOP_WORD);
    assign t1_cnt  = 27'(i_word[10:0]);
    assign t2_cnt  = i_word[26:0];
    assign t2_full = (r_offset >= FRAME_LAST);
    assign t2_last = (r_left == 27'd1);
    assign t2_end  = t2_full || t2_last;

    assign o_push_valid = i_valid && !is_noop;

    // next state
    always_comb begin
        n_mode   = r_mode;
        n_left   = r_left;
        n_reg    = r_reg;
        n_op     = r_op;
        n_single = r_single;
        n_offset = r_offset;
        if (accept) begin
            if (in_t1) begin
                n_left = r_left - 27'd1;
                if (t2_last) begin
                    n_mode = MODE_HEADER;
                end
            end else if (in_t2) begin
                n_left   = r_left - 27'd1;
                n_offset = t2_end ? 7'd0 : r_offset + 7'd1;
                if (t2_last) begin
                    n_mode = MODE_HEADER;
                end
            end else begin
                n_mode = MODE_HEADER;
                if (!is_fixed && is_t1h && !is_noop) begin
                    n_op     = i_word[28:27];
                    n_reg    = i_word[26:13];
                    n_single = (t1_cnt == 27'd1);
                    n_left   = t1_cnt;
                    n_mode   = (t1_cnt != '0) ? MODE_TYPE1 : MODE_HEADER;
                end else if (!is_fixed && is_t2h) begin
                    n_left   = t2_cnt;
                    n_offset = 7'd0;
                    n_mode   = (t2_cnt != '0) ? MODE_TYPE2 : MODE_HEADER;
                end
            end
        end
    end

    // token for the queue
    always_comb begin
        o_token      = '0;
        o_token.word = i_word;
        o_token.kind = KIND_UNKNOWN;
        if (in_t1) begin
            o_token.op_code    = r_op;
            o_token.reg_addr   = r_reg;
            o_token.word_count = r_left;
            if (r_single && (r_reg == REG_CMD) && (i_word[31:8] == '0)) begin
                o_token.kind       = KIND_COMMAND;
                o_token.known_code = cmd_known(i_word[7:0]);
            end else if (r_single && (r_reg == REG_FAR)) begin
                o_token.kind       = KIND_ADDRESS;
                o_token.known_code = 1'b1;
            end else begin
                o_token.kind       = KIND_REG_DATA;
                o_token.known_code = reg_known(r_reg);
            end
        end else if (in_t2) begin
            o_token.kind         = KIND_FRAME_DATA;
            o_token.word_count   = r_left;
            o_token.frame_offset = r_offset;
            o_token.frame_end    = t2_end;
            o_token.extra_close  = t2_full && t2_last;
        end else if (i_word == DUMMY_WORD) begin
            o_token.kind = KIND_DUMMY;
        end else if (i_word == WIDTH_SYNC_WORD) begin
            o_token.kind = KIND_WIDTH_SYNC;
        end else if (i_word == WIDTH_DET_WORD) begin
            o_token.kind = KIND_WIDTH;
        end else if (i_word == SYNC_WORD) begin
            o_token.kind = KIND_SYNC;
        end else if (is_t1h) begin
            o_token.kind       = KIND_TYPE1_HDR;
            o_token.op_code    = i_word[28:27];
            o_token.reg_addr   = i_word[26:13];
            o_token.word_count = t1_cnt;
            o_token.known_code = reg_known(i_word[26:13]);
        end else if (is_t2h) begin
            o_token.kind       = KIND_TYPE2_HDR;
            o_token.op_code    = i_word[28:27];
            o_token.word_count = t2_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_HEADER;
            r_left   <= '0;
            r_reg    <= '0;
            r_op     <= '0;
            r_single <= 1'b0;
            r_offset <= '0;
        end else begin
            r_mode   <= n_mode;
            r_left   <= n_left;
            r_reg    <= n_reg;
            r_op     <= n_op;
            r_single <= n_single;
            r_offset <= n_offset;
        end
    end

endmodule

FILE: sv/cpsp_queue.sv
// short token queue between front and back
module cpsp_queue
    import cpsp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    output logic   o_push_ready,
    input  t_token i_token,
    output logic   o_pop_valid,
    input  logic   i_pop,
    output t_token o_token
);

    t_token                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push, do_pop;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
    endfunction

    assign o_push_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_token      = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QUEUE_CNT_W'(1);
                2'b01:   r_count <= r_count - QUEUE_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/cpsp_back.sv
// back end: frame bookkeeping and the output register
`include "config_packet_stream_parser_core_assert.svh"
module cpsp_back
    import cpsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_token  i_token,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic                        r_valid;
    t_result                     r_res, n_res;
    logic                        r_any, n_any;
    logic [FRAME_COUNT_BITS-1:0] r_fcnt, n_fcnt;
    logic [23:0]                 r_run, n_run, run_a;

    logic pop, is_data, any, close1, close2;

    assign o_ready  = !r_valid || i_ready;
    assign pop      = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_result = r_res;

    assign is_data = (i_token.kind == KIND_FRAME_DATA);
    assign any     = r_any || (i_token.word != '0);
    assign close1  = is_data && i_token.frame_end;
    // empty frame after a boundary-aligned payload, or a zero-length type-2 packet
    assign close2  = (is_data && i_token.extra_close) ||
                     ((i_token.kind == KIND_TYPE2_HDR) && (i_token.word_count == '0));

    always_comb begin
        run_a  = close1 ? (any ? 24'd0 : sat_inc(r_run)) : r_run;
        n_run  = close2 ? sat_inc(run_a) : run_a;
        n_fcnt = r_fcnt + FRAME_COUNT_BITS'(close1) + FRAME_COUNT_BITS'(close2);
        n_any  = r_any;
        if (i_token.kind == KIND_TYPE2_HDR) begin
            n_any = 1'b0;
        end else if (is_data) begin
            n_any = i_token.frame_end ? 1'b0 : any;
        end
    end

    always_comb begin
        n_res                    = '0;
        n_res.kind               = i_token.kind;
        n_res.raw_word           = i_token.word;
        n_res.op_code            = i_token.op_code;
        n_res.reg_addr           = i_token.reg_addr;
        n_res.word_count         = i_token.word_count;
        n_res.known_code         = i_token.known_code;
        n_res.frame_offset       = i_token.frame_offset;
        n_res.frame_end          = i_token.frame_end;
        n_res.frame_number       = is_data ? 24'(r_fcnt) : 24'd0;
        n_res.frame_nonzero      = close1 && any;
        n_res.zero_frames_before = close1 ? r_run : 24'd0;
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_any   <= 1'b0;
            r_fcnt  <= '0;
            r_run   <= '0;
        end else begin
            if (pop) begin
                r_valid <= 1'b1;
                r_any   <= n_any;
                r_fcnt  <= n_fcnt;
                r_run   <= n_run;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    `CPSP_ASSERT(a_end_is_data, i_clk, i_rst_n, r_valid && r_res.frame_end, r_res.kind == KIND_FRAME_DATA)
    `CPSP_ASSERT(a_stats_at_end, i_clk, i_rst_n, r_valid && !r_res.frame_end, r_res.zero_frames_before == '0 && !r_res.frame_nonzero)
    `CPSP_ASSERT_NEXT(a_run_cleared, i_clk, i_rst_n, pop && close1 && any && !close2, r_run == '0)
    `CPSP_ASSERT_NEXT(a_any_cleared, i_clk, i_rst_n, pop && close1, !r_any)

endmodule

FILE: sv/config_packet_stream_parser_core.sv
// top level of the configuration packet stream parser
//
//  channel   dir  handshake               payload
//  s (word)  in   i_s_tvalid/o_s_tready   i_s_tdata = word
//  m (item)  out  o_m_tvalid/i_m_tready   o_m_tdata, o_m_tuser = kind, o_m_tlast = frame_end
//
// one word per cycle sustained while the queue has room: classification is combinational, frame update registered
// two register stages: an accepted word is written into the queue, and the back end loads
//   its result into the output register that drives o_m_tvalid when it pops the token
// a four-word queue between front and back absorbs output stalls; s side stalls
//   only when the queue is full
// the exact noop word outside a payload is consumed and produces no output word
// reset is synchronous, active low, and clears all parse and frame state
module config_packet_stream_parser_core
    import cpsp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // stream input
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,   // [31:0] word
    // stream output
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] raw_word, [33:32] op_code, [47:34] reg_addr, [74:48] word_count,
    // [75] known_code, [99:76] frame_number, [106:100] frame_offset,
    // [107] frame_nonzero, [131:108] zero_frames_before, [135:132] zero
    output logic [135:0] o_m_tdata,
    output logic [3:0]   o_m_tuser,   // [3:0] kind
    output logic         o_m_tlast    // frame_end
);

    // front to queue
    logic    push_valid, push_ready;
    t_token  push_token;
    // queue to back
    logic    pop_valid, pop_ready;
    t_token  pop_token;
    t_result result;

    // header/payload tracking and word decode
    cpsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_word       (i_s_tdata),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_token      (push_token)
    );

    // decouples decode from frame bookkeeping and output backpressure
    cpsp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_valid),
        .o_push_ready (push_ready),
        .i_token      (push_token),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop_ready),
        .o_token      (pop_token)
    );

    // frame counters and the output register
    cpsp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (pop_valid),
        .o_ready  (pop_ready),
        .i_token  (pop_token),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (result)
    );

    // pack the output word, raw_word in the low bits, zero pad on top
    assign o_m_tdata = {4'd0,
                        result.zero_frames_before,
                        result.frame_nonzero,
                        result.frame_offset,
                        result.frame_number,
                        result.known_code,
                        result.word_count,
                        result.reg_addr,
                        result.op_code,
                        result.raw_word};
    assign o_m_tuser = result.kind;
    assign o_m_tlast = result.frame_end;

endmodule

FILE: dv/config_packet_stream_parser_core_test.sv
// self-checking testbench of the configuration packet stream parser core
`timescale 1ns / 1ps

module config_packet_stream_parser_core_test;
    import cpsp_pkg::*;

    localparam logic [31:0] FRAME_MASK = 32'((64'd1 << FRAME_COUNT_BITS) - 64'd1);
    localparam int QUIET_TAIL = 200;    // last words of the run go without idling
    localparam int MAX_PRINTS = 60;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;

    // words still to be sent and results still to arrive, oldest first
    logic [31:0]  stream_words[$];
    t_result      parsed_items[$];
    int           fail_count = 0;

    // predictor copy of the parse and frame state
    t_mode        p_mode = MODE_HEADER;
    logic [26:0]  p_left = '0;
    logic [13:0]  p_reg = '0;
    logic [1:0]   p_op = '0;
    logic         p_single = 1'b0;
    logic [6:0]   p_off = '0;
    logic         p_any = 1'b0;
    logic [31:0]  p_frame = '0;
    logic [23:0]  p_zrun = '0;

    // idling state of both sides
    int           s_gap = 0;
    int           s_idle_pct = 20;
    int           m_stall = 0;
    int           m_idle_pct = 20;

    always #5 i_clk = ~i_clk;

    config_packet_stream_parser_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    // registers that the decoder knows by number
    function automatic logic is_known_reg(input logic [13:0] r);
        return (r <= 14'h0e) || (r inside {14'h10, 14'h11, 14'h16, 14'h18});
    endfunction

    // command codes that the decoder knows
    function automatic logic is_known_cmd(input logic [7:0] c);
        return (c <= 8'h0d) || (c inside {8'h0f, 8'h10, 8'h11});
    endfunction

    // one frame done: frame index wraps, zero-frame run saturates
    task automatic close_frame(input logic nonzero);
        p_frame = (p_frame + 32'd1) & FRAME_MASK;
        if (nonzero)
            p_zrun = '0;
        else if (p_zrun != 24'hffffff)
            p_zrun = p_zrun + 24'd1;
    endtask

    // expected result of one accepted stream word, advancing the predictor state
    task automatic parse_stream_word(input logic [31:0] w, output bit emits, output t_result r);
        logic nz;
        logic full;
        r = '0;
        r.raw_word = w;
        emits = 1'b1;
        if (p_mode == MODE_TYPE1 && p_left != '0) begin
            // type-1 payload: command, frame address or plain register data
            r.op_code = p_op;
            r.reg_addr = p_reg;
            r.word_count = p_left;
            if (p_single && p_reg == REG_CMD && w < 32'd256) begin
                r.kind = KIND_COMMAND;
                r.known_code = is_known_cmd(w[7:0]);
            end else if (p_single && p_reg == REG_FAR) begin
                r.kind = KIND_ADDRESS;
                r.known_code = 1'b1;
            end else begin
                r.kind = KIND_REG_DATA;
                r.known_code = is_known_reg(p_reg);
            end
            p_left = p_left - 27'd1;
            if (p_left == '0)
                p_mode = MODE_HEADER;
        end else if (p_mode == MODE_TYPE2 && p_left != '0) begin
            // type-2 payload: frame data with position and frame summary
            nz = p_any || (w != '0);
            full = (int'(p_off) + 1 >= FRAME_WORDS);
            r.kind = KIND_FRAME_DATA;
            r.word_count = p_left;
            r.frame_number = p_frame[23:0];
            r.frame_offset = p_off;
            p_left = p_left - 27'd1;
            if (full || p_left == '0) begin
                r.frame_end = 1'b1;
                r.frame_nonzero = nz;
                r.zero_frames_before = p_zrun;
                close_frame(nz);
                p_off = '0;
                p_any = 1'b0;
                if (p_left == '0) begin
                    p_mode = MODE_HEADER;
                    // payload ended on a frame boundary: an empty frame follows
                    if (full)
                        close_frame(1'b0);
                end
            end else begin
                p_off = p_off + 7'd1;
                p_any = nz;
            end
        end else begin
            p_mode = MODE_HEADER;
            if (w == DUMMY_WORD) begin
                r.kind = KIND_DUMMY;
            end else if (w == WIDTH_SYNC_WORD) begin
                r.kind = KIND_WIDTH_SYNC;
            end else if (w == WIDTH_DET_WORD) begin
                r.kind = KIND_WIDTH;
            end else if (w == SYNC_WORD) begin
                r.kind = KIND_SYNC;
            end else if (w[31:29] == TYPE1_TAG) begin
                if (w == NOOP_WORD) begin
                    // noop is swallowed without touching state
                    emits = 1'b0;
                end else begin
                    r.kind = KIND_TYPE1_HDR;
                    r.op_code = w[28:27];
                    r.reg_addr = w[26:13];
                    r.word_count = 27'(w[10:0]);
                    r.known_code = is_known_reg(w[26:13]);
                    p_op = w[28:27];
                    p_reg = w[26:13];
                    p_single = (w[10:0] == 11'd1);
                    p_left = 27'(w[10:0]);
                    if (w[10:0] != '0)
                        p_mode = MODE_TYPE1;
                end
            end else if (w[31:29] == TYPE2_TAG) begin
                r.kind = KIND_TYPE2_HDR;
                r.op_code = w[28:27];
                r.word_count = w[26:0];
                p_left = w[26:0];
                p_off = '0;
                p_any = 1'b0;
                if (w[26:0] != '0)
                    p_mode = MODE_TYPE2;
                else
                    close_frame(1'b0);  // empty payload still counts one frame
            end else begin
                r.kind = KIND_UNKNOWN;
            end
        end
    endtask

    task automatic log_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        if (fail_count < MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic match_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            log_mismatch(what, got, want);
    endtask

    // type-1 packet: header with random opcode and spare bits, then its payload
    task automatic add_type1_packet(input logic [13:0] reg_a, input logic [10:0] cnt);
        logic [31:0] w;
        stream_words.push_back({TYPE1_TAG, 2'($urandom_range(0, 3)), reg_a,
                                2'($urandom_range(0, 3)), cnt});
        for (int i = 0; i < int'(cnt); i++) begin
            case ($urandom_range(0, 3))
                0: w = 32'($urandom_range(0, 31));
                1: w = '0;
                default: w = $urandom();
            endcase
            // single command words mostly land around the command range
            if (cnt == 11'd1 && reg_a == REG_CMD && $urandom_range(0, 3) != 0)
                w = 32'($urandom_range(0, 300));
            stream_words.push_back(w);
        end
    endtask

    // type-2 packet: each frame is all zero, sparse or dense
    task automatic add_frame_packet(input logic [26:0] cnt);
        int frame_style;
        logic [31:0] w;
        frame_style = 0;
        stream_words.push_back({TYPE2_TAG, 2'($urandom_range(0, 3)), cnt});
        for (int i = 0; i < int'(cnt); i++) begin
            if (i % FRAME_WORDS == 0)
                frame_style = $urandom_range(0, 2);
            case (frame_style)
                0: w = '0;
                1: w = ($urandom_range(0, 15) == 0) ? $urandom() : 32'd0;
                default: w = $urandom();
            endcase
            stream_words.push_back(w);
        end
    endtask

    // driver: offers the oldest pending word, predicts each accepted one
    always @(posedge i_clk) begin
        t_result r;
        bit emits;
        bit hold;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_gap = 0;
        end else begin
            hold = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                parse_stream_word(s_tdata, emits, r);
                if (emits)
                    parsed_items.push_back(r);
                void'(stream_words.pop_front());
            end
            if ($urandom_range(0, 199) == 0) begin
                case ($urandom_range(0, 3))
                    0: s_idle_pct = 0;
                    1: s_idle_pct = 5;
                    2: s_idle_pct = 25;
                    default: s_idle_pct = 60;
                endcase
            end
            // a word on offer stays until taken
            if (!hold) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (stream_words.size() > QUIET_TAIL &&
                             $urandom_range(0, 99) < s_idle_pct) begin
                    s_gap = $urandom_range(0, 8);
                    s_tvalid <= 1'b0;
                end else if (stream_words.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= stream_words[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted result word against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            m_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (parsed_items.size() == 0) begin
                    log_mismatch("result with none expected", m_tdata[63:0], '0);
                end else begin
                    want = parsed_items.pop_front();
                    match_field("kind", m_tuser, want.kind);
                    match_field("raw_word", m_tdata[31:0], want.raw_word);
                    match_field("op_code", m_tdata[33:32], want.op_code);
                    match_field("reg_addr", m_tdata[47:34], want.reg_addr);
                    match_field("word_count", m_tdata[74:48], want.word_count);
                    match_field("known_code", m_tdata[75], want.known_code);
                    match_field("frame_number", m_tdata[99:76], want.frame_number);
                    match_field("frame_offset", m_tdata[106:100], want.frame_offset);
                    match_field("frame_end", m_tlast, want.frame_end);
                    match_field("frame_nonzero", m_tdata[107], want.frame_nonzero);
                    match_field("zero_frames_before", m_tdata[131:108],
                                want.zero_frames_before);
                    match_field("tdata pad", m_tdata[135:132], '0);
                end
            end
            if ($urandom_range(0, 199) == 0) begin
                case ($urandom_range(0, 3))
                    0: m_idle_pct = 0;
                    1: m_idle_pct = 5;
                    2: m_idle_pct = 25;
                    default: m_idle_pct = 60;
                endcase
            end
            if (m_stall > 0) begin
                m_stall--;
                m_tready <= 1'b0;
            end else if (stream_words.size() > QUIET_TAIL &&
                         $urandom_range(0, 99) < m_idle_pct) begin
                m_stall = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int pick;
        int sel;
        logic [13:0] reg_a;
        logic [10:0] cnt1;
        logic [26:0] cnt2;
        logic [31:0] w;

        // every fixed sync word, noop and some unknown words
        stream_words.push_back(DUMMY_WORD);
        stream_words.push_back(WIDTH_SYNC_WORD);
        stream_words.push_back(WIDTH_DET_WORD);
        stream_words.push_back(SYNC_WORD);
        stream_words.push_back(NOOP_WORD);
        stream_words.push_back(32'h00000000);
        stream_words.push_back(32'he0000000);
        stream_words.push_back(32'h60000000);
        // single-word command register packets: known, unknown, too large for a command
        stream_words.push_back({TYPE1_TAG, 2'd2, REG_CMD, 2'd0, 11'd1});
        stream_words.push_back(32'h0000000d);
        stream_words.push_back({TYPE1_TAG, 2'd2, REG_CMD, 2'd0, 11'd1});
        stream_words.push_back(32'h00000012);
        stream_words.push_back({TYPE1_TAG, 2'd2, REG_CMD, 2'd0, 11'd1});
        stream_words.push_back(32'h00000100);
        // frame address write
        stream_words.push_back({TYPE1_TAG, 2'd2, REG_FAR, 2'd0, 11'd1});
        stream_words.push_back(32'hffffffff);
        // header with all fields at their top and no payload
        stream_words.push_back({TYPE1_TAG, 2'd3, 14'h3fff, 2'd3, 11'd0});
        // two-word packet to the command register is plain data
        stream_words.push_back({TYPE1_TAG, 2'd2, REG_CMD, 2'd0, 11'd2});
        stream_words.push_back(32'h00000005);
        stream_words.push_back(32'h00000200);
        // empty frame payload, then a short one
        stream_words.push_back({TYPE2_TAG, 2'd0, 27'd0});
        stream_words.push_back({TYPE2_TAG, 2'd1, 27'd2});
        stream_words.push_back(32'h00000000);
        stream_words.push_back(32'h00000007);

        // mostly well-formed packets with random content, some loose words and noise
        while (stream_words.size() < 1900) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                case ($urandom_range(0, 5))
                    0: reg_a = REG_FAR;
                    1, 2: reg_a = REG_CMD;
                    3: reg_a = 14'($urandom_range(0, 31));
                    default: reg_a = 14'($urandom());
                endcase
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    cnt1 = 11'd1;
                else if (sel < 7)
                    cnt1 = 11'd0;
                else
                    cnt1 = 11'($urandom_range(2, 12));
                add_type1_packet(reg_a, cnt1);
            end else if (pick < 65) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: cnt2 = 27'($urandom_range(1, 8));
                    3, 4: cnt2 = 27'(FRAME_WORDS * $urandom_range(1, 2));
                    5: cnt2 = 27'(FRAME_WORDS * $urandom_range(1, 2) - 1);
                    6: cnt2 = 27'(FRAME_WORDS * $urandom_range(1, 2) + 1);
                    7: cnt2 = '0;
                    default: cnt2 = 27'($urandom_range(9, 250));
                endcase
                add_frame_packet(cnt2);
            end else if (pick < 80) begin
                case ($urandom_range(0, 4))
                    0: stream_words.push_back(DUMMY_WORD);
                    1: stream_words.push_back(WIDTH_SYNC_WORD);
                    2: stream_words.push_back(WIDTH_DET_WORD);
                    3: stream_words.push_back(SYNC_WORD);
                    default: stream_words.push_back(NOOP_WORD);
                endcase
            end else begin
                // noise; a random frame header would lock the parser for ages
                w = $urandom();
                if (w[31:29] == TYPE2_TAG)
                    w[29] = 1'b1;
                stream_words.push_back(w);
            end
        end

        // largest frame header count last, with a few of its words
        stream_words.push_back({TYPE2_TAG, 2'd3, 27'h7ffffff});
        for (int i = 0; i < 6; i++)
            stream_words.push_back((i % 2 == 0) ? 32'd0 : $urandom());

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        while (stream_words.size() != 0 || s_tvalid)
            @(posedge i_clk);
        while (parsed_items.size() != 0)
            @(posedge i_clk);
        // room for any stray word behind the last expected one
        repeat (20) @(posedge i_clk);

        if (fail_count == 0)
            $display("[config_packet_stream_parser_core] OK");
        else
            $display("[config_packet_stream_parser_core] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #(10_000_000);
        $display("[config_packet_stream_parser_core] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/cpsp_pkg.sv
sv/cpsp_front.sv
sv/cpsp_queue.sv
sv/cpsp_back.sv
sv/config_packet_stream_parser_core.sv
dv/config_packet_stream_parser_core_test.sv
